/* sv/point_to_pixel_projector_macros.svh */
// Assertion helpers for the point to pixel projector.
// All checks sample on i_clk and are off while i_rst_n is low.
`ifndef POINT_TO_PIXEL_PROJECTOR_MACROS_SVH
`define POINT_TO_PIXEL_PROJECTOR_MACROS_SVH

`define PTP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`define PTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ptp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point to pixel projector package
// Shared widths, register indexes and sideband types.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 66;
    localparam int NUM_W      = 68;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIM_CFG_W  = 13;
    localparam int COL_W      = 12;
    localparam int IDX_W      = 24;
    localparam int COLOR_W    = 8;
    localparam int MAT_REGS   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_C01 = 3'd0,
        REG_ROW0_C23 = 3'd1,
        REG_ROW1_C01 = 3'd2,
        REG_ROW1_C23 = 3'd3,
        REG_ROW2_C01 = 3'd4,
        REG_ROW2_C23 = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } t_cfg_reg;

    localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 13'd480;

    // Data that rides along with a point through the pipeline.
    typedef struct packed {
        logic                      pv;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic signed [COORD_W-1:0] depth;
    } t_side;

    // Range flags produced ahead of the divider.
    typedef struct packed {
        logic ok;
        logic negx;
        logic ovfx;
        logic negy;
        logic ovfy;
    } t_dflag;

endpackage

/* sv/ptp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point to pixel projector channels
// Point input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface ptp_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptp_pkg::COORD_W-1:0] point_x;
    logic signed [ptp_pkg::COORD_W-1:0] point_y;
    logic signed [ptp_pkg::COORD_W-1:0] point_z;
    logic [ptp_pkg::COLOR_W-1:0]        red_in;
    logic [ptp_pkg::COLOR_W-1:0]        green_in;
    logic [ptp_pkg::COLOR_W-1:0]        blue_in;
    logic                               point_valid;

    modport source (output valid, point_x, point_y, point_z, red_in, green_in, blue_in,
                    point_valid, input ready);
    modport sink (input valid, point_x, point_y, point_z, red_in, green_in, blue_in,
                  point_valid, output ready);
endinterface

interface ptp_pixel_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [ptp_pkg::COL_W-1:0]          column;
    logic [ptp_pkg::COL_W-1:0]          row_out;
    logic [ptp_pkg::IDX_W-1:0]          pixel_index;
    logic [ptp_pkg::COLOR_W-1:0]        red_out;
    logic [ptp_pkg::COLOR_W-1:0]        green_out;
    logic [ptp_pkg::COLOR_W-1:0]        blue_out;
    logic signed [ptp_pkg::COORD_W-1:0] depth_value;

    modport source (output valid, hit, column, row_out, pixel_index, red_out, green_out,
                    blue_out, depth_value, input ready);
    modport sink (input valid, hit, column, row_out, pixel_index, red_out, green_out,
                  blue_out, depth_value, output ready);
endinterface

interface ptp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ptp_pkg::CFG_IDX_W-1:0]   index;
    logic [ptp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/ptp_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point to pixel projector configuration registers
// Holds the projection matrix and the image size.
// ----------------------------------------------------------------------------
module ptp_cfg (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    ptp_cfg_if.sink                                         i_cfg,
    output logic [ptp_pkg::MAT_REGS-1:0][ptp_pkg::CFG_DATA_W-1:0] o_mat,
    output logic [ptp_pkg::DIM_CFG_W-1:0]                   o_width,
    output logic [ptp_pkg::DIM_CFG_W-1:0]                   o_height
);

    logic [ptp_pkg::MAT_REGS-1:0][ptp_pkg::CFG_DATA_W-1:0] r_mat;
    logic [ptp_pkg::DIM_CFG_W-1:0]                         r_width;
    logic [ptp_pkg::DIM_CFG_W-1:0]                         r_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat    <= '0;
            r_width  <= ptp_pkg::WIDTH_RST;
            r_height <= ptp_pkg::HEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (ptp_pkg::t_cfg_reg'(i_cfg.index))
                ptp_pkg::REG_ROW0_C01: r_mat[0] <= i_cfg.data;
                ptp_pkg::REG_ROW0_C23: r_mat[1] <= i_cfg.data;
                ptp_pkg::REG_ROW1_C01: r_mat[2] <= i_cfg.data;
                ptp_pkg::REG_ROW1_C23: r_mat[3] <= i_cfg.data;
                ptp_pkg::REG_ROW2_C01: r_mat[4] <= i_cfg.data;
                ptp_pkg::REG_ROW2_C23: r_mat[5] <= i_cfg.data;
                ptp_pkg::REG_WIDTH:    r_width  <= i_cfg.data[ptp_pkg::DIM_CFG_W-1:0];
                ptp_pkg::REG_HEIGHT:   r_height <= i_cfg.data[ptp_pkg::DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_mat    = r_mat;
    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

/* sv/ptp_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point to pixel projector matrix multiply
// Two stages: nine products, then the three row sums with the offset column.
// ----------------------------------------------------------------------------
module ptp_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_en,
    input  logic                                                  i_vld,
    input  logic signed [ptp_pkg::COORD_W-1:0]                    i_x,
    input  logic signed [ptp_pkg::COORD_W-1:0]                    i_y,
    input  logic signed [ptp_pkg::COORD_W-1:0]                    i_z,
    input  ptp_pkg::t_side                                        i_side,
    input  logic [ptp_pkg::MAT_REGS-1:0][ptp_pkg::CFG_DATA_W-1:0] i_mat,
    output logic                                                  o_vld,
    output ptp_pkg::t_side                                        o_side,
    output logic signed [ptp_pkg::SUM_W-1:0]                      o_ax,
    output logic signed [ptp_pkg::SUM_W-1:0]                      o_ay,
    output logic signed [ptp_pkg::SUM_W-1:0]                      o_wh
);

    logic                               r_v1;
    logic                               r_v2;
    ptp_pkg::t_side                     r_sd1;
    ptp_pkg::t_side                     r_sd2;
    logic signed [ptp_pkg::PROD_W-1:0]  r_prod [3][3];
    logic signed [ptp_pkg::SUM_W-1:0]   r_off  [3];
    logic signed [ptp_pkg::SUM_W-1:0]   r_acc  [3];
    logic signed [ptp_pkg::COORD_W-1:0] w_pt   [3];
    logic signed [ptp_pkg::COORD_W-1:0] w_coef [3][4];

    assign w_pt[0] = i_x;
    assign w_pt[1] = i_y;
    assign w_pt[2] = i_z;

    // Each 64-bit register holds two entries, the even column in the low half.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_coef[r][c] = $signed(i_mat[r*2 + c/2][32*(c%2) +: 32]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd1 <= i_side;
            r_sd2 <= r_sd1;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= ptp_pkg::PROD_W'(w_coef[r][c]) *
                                    ptp_pkg::PROD_W'(w_pt[c]);
                end
                r_off[r] <= ptp_pkg::SUM_W'(w_coef[r][3]) <<< FRAC_BITS;
                r_acc[r] <= ptp_pkg::SUM_W'(r_prod[r][0]) + ptp_pkg::SUM_W'(r_prod[r][1])
                          + ptp_pkg::SUM_W'(r_prod[r][2]) + r_off[r];
            end
        end
    end

    assign o_vld  = r_v2;
    assign o_side = r_sd2;
    assign o_ax   = r_acc[0];
    assign o_ay   = r_acc[1];
    assign o_wh   = r_acc[2];

endmodule

/* sv/ptp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point to pixel projector divider
// Forms the rounded numerators, then one restoring quotient bit per stage
// for both axes in parallel.
// ----------------------------------------------------------------------------
module ptp_div #(
    parameter int FRAC_BITS = 16,
    parameter int DIM_BITS  = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  ptp_pkg::t_side                   i_side,
    input  logic signed [ptp_pkg::SUM_W-1:0] i_ax,
    input  logic signed [ptp_pkg::SUM_W-1:0] i_ay,
    input  logic signed [ptp_pkg::SUM_W-1:0] i_wh,
    output logic                             o_vld,
    output ptp_pkg::t_side                   o_side,
    output ptp_pkg::t_dflag                  o_flag,
    output logic [DIM_BITS:0]                o_qx,
    output logic [DIM_BITS:0]                o_qy
);

    localparam int DW   = DIM_BITS + 1;
    localparam int RW   = ptp_pkg::NUM_W + DW + 1;
    localparam int NSTG = DW;
    // Largest raw w below 1e-5; the exact quotient is never an integer.
    localparam logic [63:0] W_THR = (64'd1 << (2 * FRAC_BITS)) / 64'd100000;

    logic signed [ptp_pkg::NUM_W-1:0] w_numx;
    logic signed [ptp_pkg::NUM_W-1:0] w_numy;
    logic signed [ptp_pkg::NUM_W-1:0] w_den;
    logic signed [RW-1:0]             w_lim;
    ptp_pkg::t_dflag                  w_flag;

    logic                             r_vld  [NSTG+1];
    ptp_pkg::t_side                   r_sd   [NSTG+1];
    ptp_pkg::t_dflag                  r_fl   [NSTG+1];
    logic signed [ptp_pkg::NUM_W-1:0] r_den  [NSTG+1];
    logic signed [RW-1:0]             r_rx   [NSTG+1];
    logic signed [RW-1:0]             r_ry   [NSTG+1];
    logic [DW-1:0]                    r_qx   [NSTG+1];
    logic [DW-1:0]                    r_qy   [NSTG+1];

    // Rounding to nearest is folded in: q = trunc((2a + w) / (2w)).
    always_comb begin
        w_numx = (ptp_pkg::NUM_W'(i_ax) <<< 1) + ptp_pkg::NUM_W'(i_wh);
        w_numy = (ptp_pkg::NUM_W'(i_ay) <<< 1) + ptp_pkg::NUM_W'(i_wh);
        w_den  = ptp_pkg::NUM_W'(i_wh) <<< 1;
        w_lim  = RW'(w_den) <<< DW;
        w_flag.ok   = i_side.pv
                    && (i_wh > $signed(ptp_pkg::SUM_W'(W_THR)))
                    && ((w_numx + w_den) > $signed(ptp_pkg::NUM_W'(0)))
                    && ((w_numy + w_den) > $signed(ptp_pkg::NUM_W'(0)));
        w_flag.negx = w_numx < $signed(ptp_pkg::NUM_W'(0));
        w_flag.negy = w_numy < $signed(ptp_pkg::NUM_W'(0));
        w_flag.ovfx = RW'(w_numx) >= w_lim;
        w_flag.ovfy = RW'(w_numy) >= w_lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0]  <= i_side;
            r_fl[0]  <= w_flag;
            r_den[0] <= w_den;
            r_rx[0]  <= RW'(w_numx);
            r_ry[0]  <= RW'(w_numy);
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
        end
    end

    // A negative numerator never subtracts, so its quotient stays zero.
    for (genvar k = 1; k <= NSTG; k++) begin : g_stage
        localparam int B = NSTG - k;
        logic signed [RW-1:0] w_t;
        logic                 w_gx;
        logic                 w_gy;

        assign w_t  = RW'(r_den[k-1]) <<< B;
        assign w_gx = r_rx[k-1] >= w_t;
        assign w_gy = r_ry[k-1] >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[k]  <= r_sd[k-1];
                r_fl[k]  <= r_fl[k-1];
                r_den[k] <= r_den[k-1];
                r_rx[k]  <= w_gx ? r_rx[k-1] - w_t : r_rx[k-1];
                r_ry[k]  <= w_gy ? r_ry[k-1] - w_t : r_ry[k-1];
                r_qx[k]  <= r_qx[k-1] | (DW'(w_gx) << B);
                r_qy[k]  <= r_qy[k-1] | (DW'(w_gy) << B);
            end
        end
    end

    assign o_vld  = r_vld[NSTG];
    assign o_side = r_sd[NSTG];
    assign o_flag = r_fl[NSTG];
    assign o_qx   = r_qx[NSTG];
    assign o_qy   = r_qy[NSTG];

endmodule

/* sv/point_to_pixel_projector.sv */
`timescale 1ns / 1ps
// Throughput: one point per cycle; every stage holds when the output item is not taken.
// The depth is set by the restoring divider, one quotient bit per stage for both axes.
// Reset clears all valid bits, zeroes the matrix and sets the image to 640 by 480.
// ----------------------------------------------------------------------------
// Point to pixel projector
// Projects 3D points through a 3x4 matrix to mirrored pixel coordinates.
// ----------------------------------------------------------------------------
`include "point_to_pixel_projector_macros.svh"

module point_to_pixel_projector #(
    parameter int FRAC_BITS = 16,
    parameter int DIM_BITS  = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptp_point_if.sink   i_point,
    ptp_pixel_if.source o_pixel,
    ptp_cfg_if.sink     i_cfg
);

    localparam int DW = DIM_BITS + 1;
    localparam int EW = (2 * DW + 1 > ptp_pkg::IDX_W) ? 2 * DW + 1 : ptp_pkg::IDX_W;
    localparam logic [15:0] DIM_MAX = 16'd1 << DIM_BITS;

    logic [ptp_pkg::MAT_REGS-1:0][ptp_pkg::CFG_DATA_W-1:0] w_mat;
    logic [ptp_pkg::DIM_CFG_W-1:0] w_wcfg;
    logic [ptp_pkg::DIM_CFG_W-1:0] w_hcfg;
    logic [DW-1:0]                 w_wd;
    logic [DW-1:0]                 w_ht;
    logic                          w_en;
    ptp_pkg::t_side                w_side_in;

    logic                             w_mvld;
    ptp_pkg::t_side                   w_mside;
    logic signed [ptp_pkg::SUM_W-1:0] w_ax;
    logic signed [ptp_pkg::SUM_W-1:0] w_ay;
    logic signed [ptp_pkg::SUM_W-1:0] w_wh;

    logic            w_dvld;
    ptp_pkg::t_side  w_dside;
    ptp_pkg::t_dflag w_dflag;
    logic [DW-1:0]   w_qx;
    logic [DW-1:0]   w_qy;

    logic                              r_ov;
    logic                              r_hit;
    logic [ptp_pkg::COL_W-1:0]         r_col;
    logic [ptp_pkg::COL_W-1:0]         r_row;
    logic [ptp_pkg::IDX_W-1:0]         r_idx;
    logic [ptp_pkg::COLOR_W-1:0]       r_red;
    logic [ptp_pkg::COLOR_W-1:0]       r_green;
    logic [ptp_pkg::COLOR_W-1:0]       r_blue;
    logic signed [ptp_pkg::COORD_W-1:0] r_depth;

    logic          n_hit;
    logic [EW-1:0] n_u;
    logic [EW-1:0] n_idx;

    ptp_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_mat    (w_mat),
        .o_width  (w_wcfg),
        .o_height (w_hcfg)
    );

    // Image sizes above 2^DIM_BITS are clamped.
    assign w_wd = ({3'b0, w_wcfg} > DIM_MAX) ? DW'(DIM_MAX) : DW'({3'b0, w_wcfg});
    assign w_ht = ({3'b0, w_hcfg} > DIM_MAX) ? DW'(DIM_MAX) : DW'({3'b0, w_hcfg});

    assign w_en          = !r_ov || o_pixel.ready;
    assign i_point.ready = w_en;

    assign w_side_in.pv    = i_point.point_valid;
    assign w_side_in.red   = i_point.red_in;
    assign w_side_in.green = i_point.green_in;
    assign w_side_in.blue  = i_point.blue_in;
    assign w_side_in.depth = i_point.point_z;

    ptp_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_point.valid),
        .i_x     (i_point.point_x),
        .i_y     (i_point.point_y),
        .i_z     (i_point.point_z),
        .i_side  (w_side_in),
        .i_mat   (w_mat),
        .o_vld   (w_mvld),
        .o_side  (w_mside),
        .o_ax    (w_ax),
        .o_ay    (w_ay),
        .o_wh    (w_wh)
    );

    ptp_div #(
        .FRAC_BITS (FRAC_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_mvld),
        .i_side  (w_mside),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_wh    (w_wh),
        .o_vld   (w_dvld),
        .o_side  (w_dside),
        .o_flag  (w_dflag),
        .o_qx    (w_qx),
        .o_qy    (w_qy)
    );

    // A negative rounded numerator truncates to zero and is always in range.
    always_comb begin
        n_hit = w_dflag.ok
              && (w_dflag.negx || (!w_dflag.ovfx && (w_qx < w_wd)))
              && (w_dflag.negy || (!w_dflag.ovfy && (w_qy < w_ht)));
        n_u   = EW'(w_wd) - EW'(1) - EW'(w_qx);
        n_idx = EW'(w_qy) * EW'(w_wd) + n_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit   <= n_hit;
            r_col   <= n_hit ? n_u[ptp_pkg::COL_W-1:0] : '0;
            r_row   <= n_hit ? ptp_pkg::COL_W'(EW'(w_qy)) : '0;
            r_idx   <= n_hit ? n_idx[ptp_pkg::IDX_W-1:0] : '0;
            r_red   <= n_hit ? w_dside.red : '0;
            r_green <= n_hit ? w_dside.green : '0;
            r_blue  <= n_hit ? w_dside.blue : '0;
            r_depth <= n_hit ? w_dside.depth : '0;
        end
    end

    assign o_pixel.valid       = r_ov;
    assign o_pixel.hit         = r_hit;
    assign o_pixel.column      = r_col;
    assign o_pixel.row_out     = r_row;
    assign o_pixel.pixel_index = r_idx;
    assign o_pixel.red_out     = r_red;
    assign o_pixel.green_out   = r_green;
    assign o_pixel.blue_out    = r_blue;
    assign o_pixel.depth_value = r_depth;

    `PTP_ASSERT(a_miss_zero, !(o_pixel.valid && !o_pixel.hit) || (o_pixel.pixel_index == '0 && o_pixel.depth_value == '0 && o_pixel.column == '0), "miss item carries nonzero payload")
    `PTP_ASSERT(a_row_range, !(o_pixel.valid && o_pixel.hit) || ({4'b0, o_pixel.row_out} < 16'(w_ht)) || (w_ht == '0), "hit row outside the image height")
    `PTP_ASSERT(a_col_range, !(o_pixel.valid && o_pixel.hit) || (w_wd == '0) || (16'(w_wd) > 16'd4096) || ({4'b0, o_pixel.column} < 16'(w_wd)), "hit column outside the image width")
    `PTP_ASSERT_NEXT(a_stall_freeze, r_ov && !o_pixel.ready, $stable(r_idx) && $stable(r_hit), "stalled pixel item changed")

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point to pixel projector testbench
// Streams 3D points through the projector under several matrix and image
// settings, predicts every pixel item and checks the output in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int     LATENCY     = 17;
    localparam int     STALL_LIMIT = 5000;
    localparam int     HOLD_CYCLES = 300;
    localparam longint W_MIN_RAW   = 42949;   // floor(2^32 / 100000)
    localparam int     ONE_Q16     = 65536;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               pv;
    } point_item_t;

    typedef struct packed {
        logic               hit;
        logic [11:0]        column;
        logic [11:0]        row;
        logic [23:0]        index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [31:0] depth;
    } pixel_item_t;

    logic i_clk;
    logic i_rst_n;

    ptp_point_if pt();
    ptp_pixel_if px();
    ptp_cfg_if   cf();

    point_to_pixel_projector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (pt),
        .o_pixel (px),
        .i_cfg   (cf)
    );

    // Shadow copy of the configuration registers.
    logic [63:0] mat_shadow [ptp_pkg::MAT_REGS];
    logic [12:0] width_shadow;
    logic [12:0] height_shadow;

    point_item_t pending_points [$];
    pixel_item_t pixels_due     [$];

    int  src_idle_pct;
    int  snk_idle_pct;
    bit  hold_start;
    bit  hold_done;
    int  hold_cnt;
    bit  pt_taken;
    int  cfg_writes;
    int  stall_cycles;
    int  fail_cnt;
    int  points_in;
    int  pixels_out;
    int  hits_seen;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic signed [95:0] entry(int r, int c);
        logic [63:0] word;
        word = mat_shadow[r * 2 + c / 2];
        return (c % 2) ? 96'($signed(word[63:32])) : 96'($signed(word[31:0]));
    endfunction

    function automatic logic signed [95:0] row_sum(int r, point_item_t p);
        return entry(r, 0) * 96'(p.x) + entry(r, 1) * 96'(p.y)
             + entry(r, 2) * 96'(p.z) + entry(r, 3) * 96'(ONE_Q16);
    endfunction

    // Rounded quotient trunc((2a + w) / 2w); returns 0 when it falls outside [0, n).
    function automatic bit axis_pos(logic signed [95:0] a, logic signed [95:0] w,
                                    logic [12:0] n, output logic [12:0] q);
        logic signed [95:0] num;
        logic signed [95:0] den;
        logic signed [95:0] lim;
        logic signed [95:0] quo;
        num = 2 * a + w;
        den = 2 * w;
        lim = den * $signed({83'd0, n});
        q   = '0;
        if (num + den <= 0) return 0;
        if (num >= lim) return 0;
        if (num >= 0) begin
            quo = num / den;
            q   = quo[12:0];
        end
        return 1;
    endfunction

    function automatic pixel_item_t project(point_item_t p);
        pixel_item_t        res;
        logic signed [95:0] ax;
        logic signed [95:0] ay;
        logic signed [95:0] wh;
        logic [12:0]        wd;
        logic [12:0]        ht;
        logic [12:0]        qx;
        logic [12:0]        qy;
        logic [47:0]        u;
        logic [47:0]        idx;
        res = '0;
        wd  = (width_shadow > 13'd4096) ? 13'd4096 : width_shadow;
        ht  = (height_shadow > 13'd4096) ? 13'd4096 : height_shadow;
        if (!p.pv) return res;
        ax = row_sum(0, p);
        ay = row_sum(1, p);
        wh = row_sum(2, p);
        if (wh <= W_MIN_RAW) return res;
        if (!axis_pos(ax, wh, wd, qx)) return res;
        if (!axis_pos(ay, wh, ht, qy)) return res;
        u   = 48'(wd) - 48'd1 - 48'(qx);
        idx = 48'(qy) * 48'(wd) + u;
        res.hit    = 1'b1;
        res.column = u[11:0];
        res.row    = qy[11:0];
        res.index  = idx[23:0];
        res.red    = p.red;
        res.green  = p.green;
        res.blue   = p.blue;
        res.depth  = p.z;
        return res;
    endfunction

    // Point driver: a new item is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!pt.valid || pt_taken)) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                pt.valid       <= 1'b1;
                pt.point_x     <= pending_points[0].x;
                pt.point_y     <= pending_points[0].y;
                pt.point_z     <= pending_points[0].z;
                pt.red_in      <= pending_points[0].red;
                pt.green_in    <= pending_points[0].green;
                pt.blue_in     <= pending_points[0].blue;
                pt.point_valid <= pending_points[0].pv;
            end else begin
                pt.valid <= 1'b0;
            end
        end
    end

    // Pixel receiver, with a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_start && !hold_done)
            px.ready <= 1'b0;
        else
            px.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (hold_start && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end
    end

    // Acceptance, prediction and checking.
    always @(posedge i_clk) begin
        point_item_t pnt;
        pixel_item_t act;
        pixel_item_t exp_px;
        if (i_rst_n) begin
            pt_taken <= pt.valid && pt.ready;
            if (pt.valid && pt.ready) begin
                pnt = pending_points.pop_front();
                pixels_due.push_back(project(pnt));
                points_in++;
            end
            if (cf.valid && cf.ready) cfg_writes <= cfg_writes + 1;
            if (px.valid && px.ready) begin
                act = {px.hit, px.column, px.row_out, px.pixel_index, px.red_out,
                       px.green_out, px.blue_out, px.depth_value};
                pixels_out++;
                if (act.hit) hits_seen++;
                if (pixels_due.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: pixel item with none expected, actual %p", $time, act);
                end else begin
                    exp_px = pixels_due.pop_front();
                    if (act !== exp_px) begin
                        fail_cnt++;
                        $display("%0t: pixel mismatch\n  expected %p\n  actual   %p",
                                 $time, exp_px, act);
                    end
                end
            end
            if ((pt.valid && pt.ready) || (px.valid && px.ready) || (cf.valid && cf.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(ptp_pkg::t_cfg_reg idx, logic [63:0] value);
        int seen;
        @(negedge i_clk);
        seen     = cfg_writes;
        cf.valid = 1'b1;
        cf.index = idx;
        cf.data  = value;
        wait (cfg_writes != seen);
        if (idx == ptp_pkg::REG_WIDTH) width_shadow = value[12:0];
        else if (idx == ptp_pkg::REG_HEIGHT) height_shadow = value[12:0];
        else mat_shadow[idx] = value;
        @(negedge i_clk);
        cf.valid = 1'b0;
    endtask

    // Simple pinhole camera: focal length one, principal point at the image center.
    task automatic set_camera(int wd, int ht);
        logic [31:0] cx;
        logic [31:0] cy;
        cx = wd * (ONE_Q16 / 2);
        cy = ht * (ONE_Q16 / 2);
        write_reg(ptp_pkg::REG_ROW0_C01, {32'd0, 32'(ONE_Q16)});
        write_reg(ptp_pkg::REG_ROW0_C23, {32'd0, cx});
        write_reg(ptp_pkg::REG_ROW1_C01, {32'(ONE_Q16), 32'd0});
        write_reg(ptp_pkg::REG_ROW1_C23, {32'd0, cy});
        write_reg(ptp_pkg::REG_ROW2_C01, 64'd0);
        write_reg(ptp_pkg::REG_ROW2_C23, {32'd0, 32'(ONE_Q16)});
        write_reg(ptp_pkg::REG_WIDTH, 64'(wd));
        write_reg(ptp_pkg::REG_HEIGHT, 64'(ht));
    endtask

    task automatic add_point(int x, int y, int z, bit pv);
        point_item_t p;
        p.x     = x;
        p.y     = y;
        p.z     = z;
        p.red   = $urandom;
        p.green = $urandom;
        p.blue  = $urandom;
        p.pv    = pv;
        pending_points.push_back(p);
    endtask

    // Points aimed near the camera image, with noise_pct percent of them unconstrained noise.
    task automatic add_random(int count, int wd, int ht, int noise_pct);
        int z;
        int du;
        int dv;
        repeat (count) begin
            if ($urandom_range(99) < noise_pct) begin
                add_point($urandom, $urandom, $urandom, $urandom_range(1));
            end else begin
                z  = $urandom_range(1 << 12, 1 << 18);
                du = $urandom_range(0, wd + 4) - wd / 2 - 2;
                dv = $urandom_range(0, ht + 4) - ht / 2 - 2;
                if ($urandom_range(19) == 0) z = -z;
                add_point(du * z + $urandom_range(0, z) - z / 2,
                          dv * z + $urandom_range(0, z) - z / 2,
                          z, $urandom_range(9) != 0);
            end
        end
    endtask

    task automatic drain;
        wait (pending_points.size() == 0 && pixels_due.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    initial begin
        pt.valid       = 1'b0;
        pt.point_x     = '0;
        pt.point_y     = '0;
        pt.point_z     = '0;
        pt.red_in      = '0;
        pt.green_in    = '0;
        pt.blue_in     = '0;
        pt.point_valid = 1'b0;
        px.ready       = 1'b0;
        cf.valid       = 1'b0;
        cf.index       = ptp_pkg::REG_ROW0_C01;
        cf.data        = '0;
        for (int i = 0; i < ptp_pkg::MAT_REGS; i++) mat_shadow[i] = '0;
        width_shadow  = ptp_pkg::WIDTH_RST;
        height_shadow = ptp_pkg::HEIGHT_RST;
        src_idle_pct  = 20;
        snk_idle_pct  = 58;
        hold_start    = 0;
        hold_done     = 0;
        hold_cnt      = 0;
        pt_taken      = 0;
        cfg_writes    = 0;
        stall_cycles  = 0;
        fail_cnt      = 0;
        points_in     = 0;
        pixels_out    = 0;
        hits_seen     = 0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset the matrix is zero, so nothing can hit.
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_point(0, 0, ONE_Q16, 1'b1);
        drain();

        // Only w depends on z, one raw step per step of z: probes the w threshold.
        write_reg(ptp_pkg::REG_ROW0_C01, 64'd0);
        write_reg(ptp_pkg::REG_ROW0_C23, 64'd0);
        write_reg(ptp_pkg::REG_ROW1_C01, 64'd0);
        write_reg(ptp_pkg::REG_ROW1_C23, 64'd0);
        write_reg(ptp_pkg::REG_ROW2_C01, 64'd0);
        write_reg(ptp_pkg::REG_ROW2_C23, 64'd1);
        add_point(0, 0, 42949, 1'b1);
        add_point(0, 0, 42950, 1'b1);
        add_point(0, 0, -5, 1'b1);
        add_point(0, 0, 0, 1'b1);
        drain();

        set_camera(640, 480);
        add_point(0, 0, ONE_Q16, 1'b1);                          // image center
        add_point(-320 * ONE_Q16, -240 * ONE_Q16, ONE_Q16, 1'b1); // corner pixel
        add_point(319 * ONE_Q16, 239 * ONE_Q16, ONE_Q16, 1'b1);   // opposite corner
        add_point(320 * ONE_Q16, 0, ONE_Q16, 1'b1);              // just off the right edge
        add_point(0, 240 * ONE_Q16, ONE_Q16, 1'b1);              // just off the bottom edge
        add_point(-320 * ONE_Q16 - ONE_Q16 / 2, 0, ONE_Q16, 1'b1); // exactly half a pixel out
        add_point(-320 * ONE_Q16 - ONE_Q16 / 4, 0, ONE_Q16, 1'b1); // quotient in (-1, 0)
        add_point(-321 * ONE_Q16, 0, ONE_Q16, 1'b1);             // a full pixel out
        add_point(0, 0, -ONE_Q16, 1'b1);                         // behind the camera
        add_point(0, 0, ONE_Q16, 1'b0);                          // invalid point
        hold_start = 1;
        add_random(500, 640, 480, 25);
        drain();

        src_idle_pct = 58;
        snk_idle_pct = 20;
        set_camera(1, 1);
        add_random(200, 1, 1, 20);
        drain();
        set_camera(4096, 4096);
        add_random(350, 4096, 4096, 20);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(ptp_pkg::REG_ROW0_C01, 64'h7FFF_FFFF_8000_0000);
        write_reg(ptp_pkg::REG_ROW0_C23, 64'h8000_0000_7FFF_FFFF);
        write_reg(ptp_pkg::REG_ROW1_C01, 64'h8000_0000_8000_0000);
        write_reg(ptp_pkg::REG_ROW1_C23, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(ptp_pkg::REG_ROW2_C01, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(ptp_pkg::REG_ROW2_C23, 64'h8000_0000_7FFF_FFFF);
        add_random(150, 640, 480, 100);
        drain();

        for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < ptp_pkg::MAT_REGS; r++)
                write_reg(ptp_pkg::t_cfg_reg'(r), {$urandom, $urandom});
            write_reg(ptp_pkg::REG_WIDTH, 64'($urandom_range(1, 4096)));
            write_reg(ptp_pkg::REG_HEIGHT, 64'($urandom_range(1, 4096)));
            add_random(200, 640, 480, 100);
            drain();
        end

        $display("Run covered %0d points and %0d pixel items, %0d of them hits,",
                 points_in, pixels_out, hits_seen);
        $display("across reset, threshold, camera, extreme and random matrix settings.");
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/ptp_pkg.sv
sv/ptp_if.sv
sv/ptp_cfg.sv
sv/ptp_mac.sv
sv/ptp_div.sv
sv/point_to_pixel_projector.sv
dv/tb.sv
